// ===== rtl/core/keyframe_vertex_blend_bounds_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the keyframe vertex blend bounds checker
// Short forms of the concurrent assertions, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_VERTEX_BLEND_BOUNDS_ASSERT_SVH
`define KEYFRAME_VERTEX_BLEND_BOUNDS_ASSERT_SVH

// Same-cycle implication.
`define KVBB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define KVBB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/kvbb_pkg.sv =====
// ---------------------------------------------------------------------------
// kvbb_pkg
// Shared types and constants of the keyframe vertex blend bounds block.
// ---------------------------------------------------------------------------
package kvbb_pkg;

  localparam int AXES     = 3;
  localparam int Q_W      = 8;
  localparam int FIX_W    = 32;
  localparam int DQ_W     = 42;   // byte * scale + translate
  localparam int DIFF_W   = 43;   // p1 - p2, also the quotient
  localparam int BL_W     = 52;   // quotient * pos and the blend
  localparam int DIV_W    = 48;   // divider magnitude, whole digits
  localparam int DIV_BITS = 8;    // quotient bits per divider cycle
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int BND_SHIFT = 37;
  localparam logic [31:0] BND_RECIP = 32'hA3D7_0A3E; // ceil(2^37 / 50)
  localparam int BND_COUNT = 2 * AXES;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_A_X = 3'd0;
  localparam logic [2:0] REG_FRAME_A_Y = 3'd1;
  localparam logic [2:0] REG_FRAME_A_Z = 3'd2;
  localparam logic [2:0] REG_FRAME_B_X = 3'd3;
  localparam logic [2:0] REG_FRAME_B_Y = 3'd4;
  localparam logic [2:0] REG_FRAME_B_Z = 3'd5;
  localparam logic [2:0] REG_BLEND_POS = 3'd6;
  localparam logic [2:0] REG_BLEND_CNT = 3'd7;

  typedef struct packed {
    logic [AXES-1:0][Q_W-1:0] qa;
    logic [AXES-1:0][Q_W-1:0] qb;
    logic                     last;
  } vert_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dividend;
    logic [Q_W-1:0]           divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIFF_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DEQ, ST_DIFF, ST_DIV, ST_BLEND, ST_SCALE, ST_OUT
  } back_st_t;

endpackage

// ===== rtl/core/kvbb_front.sv =====
// ---------------------------------------------------------------------------
// kvbb_front
// Accepts vertex transfers, unpacks them and queues them for the back end.
// ---------------------------------------------------------------------------
module kvbb_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [47:0]    in_tdata,
  input  logic           in_tlast,
  input  logic           pop,
  output logic           head_valid,
  output kvbb_pkg::vert_t head
);

  kvbb_pkg::vert_t mem_r [2];
  kvbb_pkg::vert_t wr_ent;
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  always_comb begin
    for (int i = 0; i < kvbb_pkg::AXES; i++) begin
      wr_ent.qa[i] = in_tdata[8*i +: 8];
      wr_ent.qb[i] = in_tdata[24 + 8*i +: 8];
    end
    wr_ent.last = in_tlast;
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/kvbb_div.sv =====
// ---------------------------------------------------------------------------
// kvbb_div
// Iterative signed by unsigned divider, eight quotient bits per cycle,
// truncating toward zero.
// ---------------------------------------------------------------------------
module kvbb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  kvbb_pkg::div_req_t  req,
  output kvbb_pkg::div_rsp_t  rsp
);

  logic                               busy_r, done_r, neg_r;
  logic [$clog2(kvbb_pkg::DIV_STEPS)-1:0] step_r;
  logic [kvbb_pkg::DIV_W-1:0]         mag_r, mag_nxt;
  logic [7:0]                         rem_r, rem_nxt, dsr_r;
  logic [kvbb_pkg::DIFF_W-1:0]        abs_in;
  logic [8:0]                         t;

  assign abs_in = req.dividend[kvbb_pkg::DIFF_W-1] ? -req.dividend : req.dividend;

  // one radix-256 digit: eight restoring steps on a nine-bit remainder
  always_comb begin
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    t       = 9'd0;
    for (int k = 0; k < kvbb_pkg::DIV_BITS; k++) begin
      t       = {rem_nxt, mag_nxt[kvbb_pkg::DIV_W-1]};
      mag_nxt = {mag_nxt[kvbb_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dsr_r}) begin
        t          = t - {1'b0, dsr_r};
        mag_nxt[0] = 1'b1;
      end
      rem_nxt = t[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mag_r <= {{(kvbb_pkg::DIV_W-kvbb_pkg::DIFF_W){1'b0}}, abs_in};
      rem_r <= 8'd0;
      dsr_r <= req.divisor;
      neg_r <= req.dividend[kvbb_pkg::DIFF_W-1];
    end else if (busy_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == ($bits(step_r))'(kvbb_pkg::DIV_STEPS - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == ($bits(step_r))'(kvbb_pkg::DIV_STEPS - 1)) busy_r <= 1'b0;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -mag_r[kvbb_pkg::DIFF_W-1:0] : mag_r[kvbb_pkg::DIFF_W-1:0];

endmodule

// ===== rtl/core/kvbb_back.sv =====
// ---------------------------------------------------------------------------
// kvbb_back
// Blends one vertex axis by axis, tracks pass bounds, scales them by 1/50
// and holds the result in the output register.
// ---------------------------------------------------------------------------
module kvbb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  kvbb_pkg::vert_t      head,
  output logic                 pop,
  input  logic [63:0]          frame_a [3],
  input  logic [63:0]          frame_b [3],
  input  logic [7:0]           blend_pos,
  input  logic [7:0]           blend_cnt,
  output kvbb_pkg::div_req_t   div_req,
  input  kvbb_pkg::div_rsp_t   div_rsp,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [287:0]         out_tdata,
  output logic                 out_tlast
);

  localparam int BL_W = kvbb_pkg::BL_W;
  localparam int DQ_W = kvbb_pkg::DQ_W;

  kvbb_pkg::back_st_t st_r, st_nxt;
  kvbb_pkg::vert_t    cur_r;
  logic [1:0]         axis_r;
  logic [2:0]         sc_cnt_r, sc_dst_r;
  logic signed [DQ_W-1:0] p1_r, p2_r;
  logic signed [BL_W-1:0] prod_r;
  logic signed [31:0] res_r [3];
  logic signed [31:0] least_r [3];
  logic signed [31:0] most_r [3];
  logic signed [31:0] low_r [3];
  logic signed [31:0] high_r [3];
  logic               pass_start_r;
  logic [63:0]        sc_prod_r;
  logic               sc_neg_r;
  logic               out_valid_r, out_last_r;
  logic [287:0]       out_data_r;

  logic signed [40:0] mul_a, mul_b;
  logic signed [DQ_W-1:0] p1_c, p2_c;
  logic signed [BL_W-1:0] prod_c, blend_c;
  logic signed [31:0] sat_c, sc_src, sc_res;
  logic [31:0]        sc_mag;
  logic [1:0]         sc_idx;
  logic [26:0]        sc_q;
  logic               out_load;

  // dequantize both frames of the current axis
  always_comb begin
    mul_a = $signed({1'b0, cur_r.qa[axis_r]}) * $signed(frame_a[axis_r][63:32]);
    mul_b = $signed({1'b0, cur_r.qb[axis_r]}) * $signed(frame_b[axis_r][63:32]);
    p1_c  = {mul_a[40], mul_a} + {{10{frame_a[axis_r][31]}}, frame_a[axis_r][31:0]};
    p2_c  = {mul_b[40], mul_b} + {{10{frame_b[axis_r][31]}}, frame_b[axis_r][31:0]};
  end

  assign div_req.start    = (st_r == kvbb_pkg::ST_DIFF);
  assign div_req.dividend = {p1_r[DQ_W-1], p1_r} - {p2_r[DQ_W-1], p2_r};
  assign div_req.divisor  = (blend_cnt == 8'd0) ? 8'd1 : blend_cnt;

  // quotient times pos, then blend and saturate
  always_comb begin
    prod_c  = BL_W'(div_rsp.quot * $signed({1'b0, blend_pos}));
    blend_c = {{(BL_W-DQ_W){p1_r[DQ_W-1]}}, p1_r} - prod_r;
    if (blend_c[BL_W-1:31] == '0 || blend_c[BL_W-1:31] == '1) begin
      sat_c = blend_c[31:0];
    end else begin
      sat_c = blend_c[BL_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // bound scaling: magnitude times reciprocal, sign restored on the registered product
  always_comb begin
    sc_idx = (sc_cnt_r < 3'd3) ? sc_cnt_r[1:0] : 2'(sc_cnt_r - 3'd3);
    sc_src = (sc_cnt_r < 3'd3) ? least_r[sc_idx] : most_r[sc_idx];
    sc_mag = sc_src[31] ? -sc_src : sc_src;
    sc_q   = sc_prod_r[63:kvbb_pkg::BND_SHIFT];
    sc_res = sc_neg_r ? -$signed({5'd0, sc_q}) : $signed({5'd0, sc_q});
  end

  assign out_load = (st_r == kvbb_pkg::ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    st_nxt = st_r;
    pop    = 1'b0;
    unique case (st_r)
      kvbb_pkg::ST_IDLE: begin
        if (head_valid) begin
          pop    = 1'b1;
          st_nxt = kvbb_pkg::ST_DEQ;
        end
      end
      kvbb_pkg::ST_DEQ:   st_nxt = kvbb_pkg::ST_DIFF;
      kvbb_pkg::ST_DIFF:  st_nxt = kvbb_pkg::ST_DIV;
      kvbb_pkg::ST_DIV:   if (div_rsp.done) st_nxt = kvbb_pkg::ST_BLEND;
      kvbb_pkg::ST_BLEND: st_nxt = (axis_r == 2'd2) ? kvbb_pkg::ST_SCALE : kvbb_pkg::ST_DEQ;
      kvbb_pkg::ST_SCALE: if (sc_cnt_r == 3'(kvbb_pkg::BND_COUNT)) st_nxt = kvbb_pkg::ST_OUT;
      kvbb_pkg::ST_OUT:   if (out_load) st_nxt = kvbb_pkg::ST_IDLE;
      default:            st_nxt = kvbb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kvbb_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      kvbb_pkg::ST_IDLE: begin
        cur_r <= head;
      end
      kvbb_pkg::ST_DEQ: begin
        p1_r <= p1_c;
        p2_r <= p2_c;
      end
      kvbb_pkg::ST_DIV: begin
        if (div_rsp.done) prod_r <= prod_c;
      end
      kvbb_pkg::ST_BLEND: begin
        res_r[axis_r] <= sat_c;
      end
      kvbb_pkg::ST_SCALE: begin
        sc_prod_r <= 64'(sc_mag) * 64'(kvbb_pkg::BND_RECIP);
        sc_neg_r  <= sc_src[31];
        sc_dst_r  <= sc_cnt_r;
        if (sc_cnt_r != 3'd0) begin
          if (sc_dst_r < 3'd3) low_r[sc_dst_r[1:0]] <= sc_res;
          else                 high_r[2'(sc_dst_r - 3'd3)] <= sc_res;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {high_r[2], high_r[1], high_r[0], low_r[2], low_r[1], low_r[0],
                     res_r[2], res_r[1], res_r[0]};
      out_last_r <= cur_r.last;
    end
  end

  // control and bound state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r       <= 2'd0;
      sc_cnt_r     <= 3'd0;
      pass_start_r <= 1'b1;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        least_r[i] <= '0;
        most_r[i]  <= '0;
      end
    end else begin
      if (st_r == kvbb_pkg::ST_IDLE) begin
        axis_r   <= 2'd0;
        sc_cnt_r <= 3'd0;
      end
      if (st_r == kvbb_pkg::ST_BLEND) begin
        axis_r <= axis_r + 2'd1;
        if (pass_start_r || sat_c < least_r[axis_r]) least_r[axis_r] <= sat_c;
        if (pass_start_r || sat_c > most_r[axis_r])  most_r[axis_r]  <= sat_c;
      end
      if (st_r == kvbb_pkg::ST_SCALE) sc_cnt_r <= sc_cnt_r + 3'd1;
      if (out_load) begin
        pass_start_r <= cur_r.last;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/keyframe_vertex_blend_bounds.sv =====
// ---------------------------------------------------------------------------
// keyframe_vertex_blend_bounds
// Keyframe vertex blend with running per-axis bounds over a pass.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload
// in_*      slave      six quantized bytes (frame a xyz, frame b xyz), tlast
// out_*     master     blended xyz, low xyz / 50, high xyz / 50, tlast
// cfg_*     APB slave  8 registers of 64 bits at byte address 8*i
//
// For each vertex the sequencer pops it, then per axis dequantizes, forms the
// difference and starts the shared divider, waits for the divider (six radix-256
// digits, then done) and blends, then scales the six bounds through one
// multiplier and loads the output register.
// Reset is synchronous and active low; it clears the queue, the sequencer, the
// bounds and the registers. The two-entry queue takes vertices while out_tready stalls.
// ---------------------------------------------------------------------------
module keyframe_vertex_blend_bounds (
  input  logic         clk,
  input  logic         rst_n,
  // vert_a_x[7:0], vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z[47:40]
  input  logic [47:0]  in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tlast,     // last_vertex
  // pos_x[31:0], pos_y, pos_z, low_x, low_y, low_z, high_x, high_y, high_z
  output logic [287:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tlast,    // pass_done
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [63:0]        frame_a_r [3];
  logic [63:0]        frame_b_r [3];
  logic [7:0]         blend_pos_r, blend_cnt_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;
  logic               pop, head_valid;
  kvbb_pkg::vert_t    head;
  kvbb_pkg::div_req_t div_req;
  kvbb_pkg::div_rsp_t div_rsp;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // register file: write on the access phase of an APB write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        frame_a_r[i] <= 64'd0;
        frame_b_r[i] <= 64'd0;
      end
      blend_pos_r <= 8'd0;
      blend_cnt_r <= 8'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        kvbb_pkg::REG_FRAME_A_X: frame_a_r[0] <= cfg_pwdata;
        kvbb_pkg::REG_FRAME_A_Y: frame_a_r[1] <= cfg_pwdata;
        kvbb_pkg::REG_FRAME_A_Z: frame_a_r[2] <= cfg_pwdata;
        kvbb_pkg::REG_FRAME_B_X: frame_b_r[0] <= cfg_pwdata;
        kvbb_pkg::REG_FRAME_B_Y: frame_b_r[1] <= cfg_pwdata;
        kvbb_pkg::REG_FRAME_B_Z: frame_b_r[2] <= cfg_pwdata;
        kvbb_pkg::REG_BLEND_POS: blend_pos_r  <= cfg_pwdata[7:0];
        kvbb_pkg::REG_BLEND_CNT: blend_cnt_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      kvbb_pkg::REG_FRAME_A_X: cfg_prdata = frame_a_r[0];
      kvbb_pkg::REG_FRAME_A_Y: cfg_prdata = frame_a_r[1];
      kvbb_pkg::REG_FRAME_A_Z: cfg_prdata = frame_a_r[2];
      kvbb_pkg::REG_FRAME_B_X: cfg_prdata = frame_b_r[0];
      kvbb_pkg::REG_FRAME_B_Y: cfg_prdata = frame_b_r[1];
      kvbb_pkg::REG_FRAME_B_Z: cfg_prdata = frame_b_r[2];
      kvbb_pkg::REG_BLEND_POS: cfg_prdata = {56'd0, blend_pos_r};
      kvbb_pkg::REG_BLEND_CNT: cfg_prdata = {56'd0, blend_cnt_r};
      default:                 cfg_prdata = 64'd0;
    endcase
  end

  // front: accept and queue vertex transfers
  kvbb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // shared divider for the three axis blends
  kvbb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back: blend, bounds, scaling and output register
  kvbb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .frame_a    (frame_a_r),
    .frame_b    (frame_b_r),
    .blend_pos  (blend_pos_r),
    .blend_cnt  (blend_cnt_r),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/kvbb_checker.sv =====
// ---------------------------------------------------------------------------
// kvbb_checker
// Port-level checks of the keyframe vertex blend bounds block.
// ---------------------------------------------------------------------------
`include "keyframe_vertex_blend_bounds_assert.svh"

module kvbb_checker (
  input logic         clk,
  input logic         rst_n,
  input logic [287:0] out_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic         out_tlast
);

  // a stalled result holds
  `KVBB_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // scaled minimum never above scaled maximum
  `KVBB_ASSERT_IMP(a_bounds_order, out_tvalid, ($signed(out_tdata[127:96]) <= $signed(out_tdata[223:192])) && ($signed(out_tdata[159:128]) <= $signed(out_tdata[255:224])) && ($signed(out_tdata[191:160]) <= $signed(out_tdata[287:256])))

  // a non-negative x position is not below the scaled x minimum
  `KVBB_ASSERT_IMP(a_low_x, out_tvalid && !out_tdata[31], $signed(out_tdata[127:96]) <= $signed(out_tdata[31:0]))

  // a non-positive x position is not above the scaled x maximum
  `KVBB_ASSERT_IMP(a_high_x, out_tvalid && (out_tdata[31] || out_tdata[31:0] == 32'd0), $signed(out_tdata[223:192]) >= $signed(out_tdata[31:0]))

endmodule

bind keyframe_vertex_blend_bounds kvbb_checker u_kvbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast)
);
